FILE: hdl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// No dependencies; imported by the top module and tccw_sweep.
`timescale 1ns / 1ps

package tccw_pkg;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_COLS   = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS   = 2'd1;
  localparam logic [1:0] REG_DEFAULT_FG = 2'd2;
  localparam logic [1:0] REG_DEFAULT_BG = 2'd3;

  // control characters
  localparam logic [15:0] CODE_BS = 16'h0008;
  localparam logic [15:0] CODE_LF = 16'h000A;
  localparam logic [15:0] CODE_CR = 16'h000D;

  // register reset values
  localparam logic [7:0]  RESET_NUM_COLS = 8'd80;
  localparam logic [6:0]  RESET_NUM_ROWS = 7'd25;
  localparam logic [23:0] RESET_FG       = 24'hCCCCCC;
  localparam logic [23:0] RESET_BG       = 24'h050505;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] char_code;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [5:0]  read_row;
    logic [6:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_line;
    logic        scrolled;
    logic [15:0] cell_char;
    logic [23:0] cell_fg;
    logic [23:0] cell_bg;
  } rsp_t;

  typedef struct packed {
    logic [15:0] code;
    logic [23:0] fg;
    logic [23:0] bg;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // controls for the grid sweep counter
  typedef struct packed {
    logic load;
    logic step;
  } sweep_ctl_t;

endpackage

FILE: hdl/text_console_cell_writer_top.sv
// Text console cell writer: cell grid store, cursor and command sequencer.
// Depends on tccw_pkg, tccw_ram and tccw_sweep.
`timescale 1ns / 1ps
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+-------------------------------
//   cmd     | in  | cmd_valid/cmd_stall  | tccw_pkg::cmd_t (one command)
//   rsp     | out | rsp_valid/rsp_stall  | tccw_pkg::rsp_t (one result)
//   cfg     | in  | cfg_wr_en            | cfg_index, cfg_data (24 bits)
//
// Sequence: every command passes S_EXEC and S_DONE; backspace adds S_BS_WR
//   (cell read in S_EXEC, written back in S_BS_WR) and an in-range read
//   adds S_RD_WAIT. The single RAM write/read port pair sets this.
// Clear writes the active grid one cell a cycle; a scroll copies each cell
//   of rows 1 to rows-1 up a row, reading it in S_SCR_RD and writing it in
//   S_SCR_WR, then blanks the new bottom row one cell a cycle.
// Reset: synchronous; afterwards the whole store (MAX_ROWS*MAX_COLS cells,
//   8192 at the defaults) is filled with blanks before cmd_stall drops.
// Stalls: one command at a time; a finished result sits in the rsp register,
//   so the next command is taken while it waits.

module text_console_cell_writer_top #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  tccw_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tccw_pkg::rsp_t  rsp,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [23:0]     cfg_data
);

  import tccw_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);

  // sequencer states
  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EXEC      = 4'd2;
  localparam logic [3:0] S_BS_WR     = 4'd3;
  localparam logic [3:0] S_RD_WAIT   = 4'd4;
  localparam logic [3:0] S_CLR       = 4'd5;
  localparam logic [3:0] S_SCR_RD    = 4'd6;
  localparam logic [3:0] S_SCR_WR    = 4'd7;
  localparam logic [3:0] S_SCR_BLANK = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  // active grid size, as last index; 0 acts as 1, oversize acts as max
  function automatic logic [CW-1:0] col_last_of(input logic [7:0] n);
    if (n == 8'd0) return '0;
    if (int'(n) > MAX_COLS) return CW'(MAX_COLS - 1);
    return CW'(n - 8'd1);
  endfunction

  function automatic logic [RW-1:0] row_last_of(input logic [6:0] n);
    if (n == 7'd0) return '0;
    if (int'(n) > MAX_ROWS) return RW'(MAX_ROWS - 1);
    return RW'(n - 7'd1);
  endfunction

  logic [3:0]    state, state_next;
  cmd_t          item;
  logic [CW-1:0] col_pos, col_next;
  logic [RW-1:0] row_pos, row_next;
  logic          scrolled_flag, scrolled_next;
  cell_t         rd_cell, cell_next;

  logic [7:0]    num_cols;
  logic [6:0]    num_rows;
  logic [23:0]   default_fg;
  logic [23:0]   default_bg;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;

  logic          wrap_row;
  logic          rsp_load;
  rsp_t          rsp_word;

  // store port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  cell_t             wr_cell;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  cell_t             mem_q;

  // sweep counter
  sweep_ctl_t    sw_ctl;
  logic [RW-1:0] sw_first;
  logic [RW-1:0] sw_row_last;
  logic [CW-1:0] sw_col_last;
  logic [RW-1:0] sw_row;
  logic [CW-1:0] sw_col;
  logic          sw_last;

  assign col_last  = col_last_of(num_cols);
  assign row_last  = row_last_of(num_rows);
  assign cmd_stall = (state != S_IDLE);
  assign mem_q     = ram_rdata;

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (wr_cell),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // reset fill walks the whole store, copy stops one row short of the bottom
  always_comb begin
    if (state == S_INIT) begin
      sw_row_last = RW'(MAX_ROWS - 1);
      sw_col_last = CW'(MAX_COLS - 1);
    end else if (state == S_SCR_RD || state == S_SCR_WR) begin
      sw_row_last = RW'(row_last - RW'(1));
      sw_col_last = col_last;
    end else begin
      sw_row_last = row_last;
      sw_col_last = col_last;
    end
  end

  tccw_sweep #(
    .RW (RW),
    .CW (CW)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sw_ctl),
    .row_first (sw_first),
    .row_last  (sw_row_last),
    .col_last  (sw_col_last),
    .row       (sw_row),
    .col       (sw_col),
    .last      (sw_last)
  );

  always_comb begin
    state_next    = state;
    col_next      = col_pos;
    row_next      = row_pos;
    scrolled_next = scrolled_flag;
    cell_next     = rd_cell;
    wrap_row      = 1'b0;
    rsp_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {sw_row, sw_col};
    wr_cell       = '{code: '0, fg: default_fg, bg: default_bg};
    ram_re        = 1'b0;
    ram_raddr     = {sw_row, sw_col};
    sw_ctl        = '0;
    sw_first      = '0;

    unique case (state)
      S_INIT: begin
        ram_we      = 1'b1;
        wr_cell     = '{code: '0, fg: RESET_FG, bg: RESET_BG};
        sw_ctl.step = 1'b1;
        if (sw_last) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        scrolled_next = 1'b0;
        cell_next     = '0;
        state_next    = S_DONE;
        unique case (item.operation)
          OP_PUT: begin
            if (item.char_code == CODE_LF || item.char_code == CODE_CR) begin
              col_next = '0;
              wrap_row = 1'b1;
            end else if (item.char_code == CODE_BS) begin
              // step back, wrapping to the end of the previous row
              if (col_pos != '0) begin
                col_next = CW'(col_pos - CW'(1));
              end else if (row_pos != '0) begin
                row_next = RW'(row_pos - RW'(1));
                col_next = col_last;
              end
              ram_re     = 1'b1;
              ram_raddr  = {row_next, col_next};
              state_next = S_BS_WR;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = {row_pos, col_pos};
              wr_cell   = '{code: item.char_code, fg: item.fg_color, bg: item.bg_color};
              if (col_pos == col_last) begin
                col_next = '0;
                wrap_row = 1'b1;
              end else begin
                col_next = CW'(col_pos + CW'(1));
              end
            end
            if (wrap_row) begin
              if (row_pos == row_last) begin
                scrolled_next = 1'b1;
                row_next      = row_last;
                sw_ctl.load   = 1'b1;
                // single-row grid: nothing to copy, just blank row 0
                state_next    = (row_last == '0) ? S_SCR_BLANK : S_SCR_RD;
              end else begin
                row_next = RW'(row_pos + RW'(1));
              end
            end
          end
          OP_CLEAR: begin
            col_next    = '0;
            row_next    = '0;
            sw_ctl.load = 1'b1;
            state_next  = S_CLR;
          end
          OP_READ: begin
            // beyond the store reads as zero; outside the active grid is fine
            if (int'(item.read_row) < MAX_ROWS && int'(item.read_col) < MAX_COLS) begin
              ram_re     = 1'b1;
              ram_raddr  = {RW'(item.read_row), CW'(item.read_col)};
              state_next = S_RD_WAIT;
            end
          end
          default: begin
          end
        endcase
      end

      S_BS_WR: begin
        // blank the code only, colors kept
        ram_we     = 1'b1;
        ram_waddr  = {row_pos, col_pos};
        wr_cell    = '{code: '0, fg: mem_q.fg, bg: mem_q.bg};
        state_next = S_DONE;
      end

      S_RD_WAIT: begin
        cell_next  = mem_q;
        state_next = S_DONE;
      end

      S_CLR: begin
        ram_we      = 1'b1;
        sw_ctl.step = 1'b1;
        if (sw_last) begin
          state_next = S_DONE;
        end
      end

      S_SCR_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = {RW'(sw_row + RW'(1)), sw_col};
        state_next = S_SCR_WR;
      end

      S_SCR_WR: begin
        ram_we  = 1'b1;
        wr_cell = mem_q;
        if (sw_last) begin
          sw_ctl.load = 1'b1;
          sw_first    = row_last;
          state_next  = S_SCR_BLANK;
        end else begin
          sw_ctl.step = 1'b1;
          state_next  = S_SCR_RD;
        end
      end

      S_SCR_BLANK: begin
        ram_we      = 1'b1;
        sw_ctl.step = 1'b1;
        if (sw_last) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // shrinking the grid pulls the cursor inside it
    if (cfg_wr_en) begin
      if (cfg_index == REG_NUM_COLS && col_pos > col_last_of(cfg_data[7:0])) begin
        col_next = col_last_of(cfg_data[7:0]);
      end
      if (cfg_index == REG_NUM_ROWS && row_pos > row_last_of(cfg_data[6:0])) begin
        row_next = row_last_of(cfg_data[6:0]);
      end
    end
  end

  always_comb begin
    rsp_word = '{
      cursor_column: 7'(col_pos),
      cursor_line:   6'(row_pos),
      scrolled:      scrolled_flag,
      cell_char:     rd_cell.code,
      cell_fg:       rd_cell.fg,
      cell_bg:       rd_cell.bg
    };
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      col_pos    <= '0;
      row_pos    <= '0;
      rsp_valid  <= 1'b0;
      num_cols   <= RESET_NUM_COLS;
      num_rows   <= RESET_NUM_ROWS;
      default_fg <= RESET_FG;
      default_bg <= RESET_BG;
    end else begin
      state   <= state_next;
      col_pos <= col_next;
      row_pos <= row_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_NUM_COLS:   num_cols   <= cfg_data[7:0];
          REG_NUM_ROWS:   num_rows   <= cfg_data[6:0];
          REG_DEFAULT_FG: default_fg <= cfg_data;
          REG_DEFAULT_BG: default_bg <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
    scrolled_flag <= scrolled_next;
    rd_cell       <= cell_next;
    if (rsp_load) begin
      rsp <= rsp_word;
    end
  end

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while another is in flight");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (col_pos <= col_last) && (row_pos <= row_last))
    else $error("cursor outside active grid");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    rsp_load && scrolled_flag |-> row_pos == row_last)
    else $error("scroll result without cursor on bottom row");

  a_cell_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_load && item.operation != OP_READ |-> rd_cell == '0)
    else $error("cell fields nonzero on non-read result");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_DONE |-> !ram_we)
    else $error("store written outside a command");

endmodule

FILE: hdl/tccw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/tccw_sweep.sv
// Row/column sweep counter shared by reset fill, clear and scroll.
// Depends on tccw_pkg for the control struct.
`timescale 1ns / 1ps

module tccw_sweep #(
  parameter int RW = 6,
  parameter int CW = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tccw_pkg::sweep_ctl_t   ctl,
  input  logic [RW-1:0]          row_first,
  input  logic [RW-1:0]          row_last,
  input  logic [CW-1:0]          col_last,
  output logic [RW-1:0]          row,
  output logic [CW-1:0]          col,
  output logic                   last
);

  import tccw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (ctl.load) begin
      row <= row_first;
      col <= '0;
    end else if (ctl.step) begin
      if (col == col_last) begin
        col <= '0;
        row <= RW'(row + RW'(1));
      end else begin
        col <= CW'(col + CW'(1));
      end
    end
  end

  assign last = (row == row_last) && (col == col_last);

endmodule
